// ===== rtl/adtsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package adtsc_pkg;

  // field widths
  localparam int ANGLE_W     = 12;
  localparam int TIME_W      = 32;
  localparam int STEP_W      = 13;
  localparam int THR_W       = 12;
  localparam int SETTLE_W    = 16;
  localparam int MAXP_W      = 6;
  localparam int COUNT_W     = 32;
  localparam int PEND_W      = 7;
  localparam int DELTA_W     = 13;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  // defaults
  localparam int ANGLE_BITS_DEF = 12;
  localparam int STEP_MAX       = 4096;
  localparam int STEP_RESET     = 12;
  localparam int THR_RESET      = 1;
  localparam int SETTLE_RESET   = 40;
  localparam int MAXP_RESET     = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COUNTS  = 2'd0,
    CFG_MOVE_THRESH  = 2'd1,
    CFG_IDLE_TIME    = 2'd2,
    CFG_MAX_PENDING  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_SAMPLE  = 1'b0,
    OP_CONSUME = 1'b1
  } op_e;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/adtsc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module adtsc_div #(
  parameter int DVD_W = 13
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start_i,
  input  wire  [DVD_W-1:0]                  dividend_i,
  input  wire  [adtsc_pkg::STEP_W-1:0]      divisor_i,
  output adtsc_pkg::div_stat_t              stat_o,
  output logic [DVD_W-1:0]                  quotient_o,
  output logic [adtsc_pkg::STEP_W-1:0]      remainder_o
);
  import adtsc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [STEP_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0] dvs_q, dvs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [STEP_W:0]   shifted;
  logic [STEP_W:0]   trial;
  logic              fits;

  // one restoring step a cycle
  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = CNT_W'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? trial[STEP_W-1:0] : shifted[STEP_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = quo_q;
  assign remainder_o  = rem_q;

endmodule

`default_nettype wire

// ===== rtl/angle_to_detent_step_counter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Turns timestamped absolute angle samples into signed detent steps. Each
// sample item is compared with the previous angle over the shortest way
// around the turn; a change of at least the motion threshold goes into an
// accumulator, whole multiples of step_counts move the 32-bit detent count
// and a pending counter that saturates at +/- max_pending, and the remainder
// stays (truncated toward zero). A still sample clears the accumulator once
// more than the settle time has passed since the last motion. The first
// sample after reset only sets the reference. A consume item (tuser high)
// returns the pending steps and clears them. Every item gives exactly one
// result item. A consume, the first sample or a still sample goes from
// accept straight to the output state; a moving sample first passes the
// divide state, where the restoring divider makes one quotient bit a cycle.
// The slave side is ready whenever no item is in work, also while a result
// waits in the output register. Configuration writes go to cfg_index_i /
// cfg_wdata_i while cfg_we_i is high; the user must keep the block idle
// for them, which the block itself does not enforce.
module angle_to_detent_step_counter_unit #(
  parameter int ANGLE_BITS = adtsc_pkg::ANGLE_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // slave side
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // angle [11:0], time_ms [43:12], zero [47:44]
  input  wire  [adtsc_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // operation [0]
  input  wire                                  s_axis_tuser_i,
  // master side
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // detent_count [31:0], pending_steps [38:32], consumed_steps [45:39],
  // has_steps [46], reference_angle [58:47], angle_delta [71:59]
  output logic [adtsc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // configuration writes
  input  wire                                  cfg_we_i,
  input  wire  [adtsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [adtsc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import adtsc_pkg::*;

  // derived widths
  localparam int AW    = ANGLE_BITS;
  localparam int EW    = (AW > ANGLE_W) ? AW : ANGLE_W;    // angle extension
  localparam int DW    = AW + 1;                          // wrapped delta
  localparam int ACC_W = EW + 2;                          // accumulator
  localparam int MW    = ACC_W - 1;                       // accumulator magnitude
  localparam int PW    = MW + 2;                          // pending arithmetic
  localparam int CW    = (DW > THR_W) ? DW : THR_W;       // threshold compare
  localparam int XW    = (DW > DELTA_W) ? DW : DELTA_W;   // delta output extension

  localparam logic signed [AW+1:0] HALF = (AW + 2)'(2 ** (AW - 1));
  localparam logic signed [AW+1:0] FULL = (AW + 2)'(2 ** AW);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e st_q, st_d;

  // configuration
  logic [STEP_W-1:0]   step_q;
  logic [THR_W-1:0]    thr_q;
  logic [SETTLE_W-1:0] settle_q;
  logic [MAXP_W-1:0]   maxp_q;
  logic [STEP_W-1:0]   step_wr;

  // block state
  logic                     primed_q, primed_d;
  logic [AW-1:0]            prev_angle_q, prev_angle_d;
  logic signed [DW-1:0]     prev_delta_q, prev_delta_d;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic [COUNT_W-1:0]       total_q, total_d;
  logic signed [PEND_W-1:0] pend_q, pend_d;
  logic [TIME_W-1:0]        motion_q, motion_d;
  logic signed [PEND_W-1:0] consumed_q, consumed_d;
  logic                     neg_q, neg_d;

  // output register
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_load;
  logic                   slot_free;

  // input item fields
  logic [ANGLE_W-1:0] in_angle;
  logic [TIME_W-1:0]  in_time;
  logic               in_accept;
  op_e                in_op;

  // sample datapath
  logic [EW-1:0]            ang_ext;
  logic [AW-1:0]            ang;
  logic signed [AW+1:0]     diff_raw, diff_w;
  logic signed [DW-1:0]     delta;
  logic [DW-1:0]            delta_abs;
  logic                     still;
  logic [TIME_W-1:0]        elapsed;
  logic signed [ACC_W-1:0]  acc_sum, acc_abs;
  logic                     div_start;

  // divider side
  div_stat_t                div_stat;
  logic [MW-1:0]            quo;
  logic [STEP_W-1:0]        rem;
  logic signed [ACC_W-1:0]  rem_s;
  logic signed [PW-1:0]     p_ext, q_ext, lim, p_new;

  // output fields
  logic [EW-1:0]            ref_ext;
  logic signed [XW-1:0]     delta_ext;

  assign in_angle  = s_axis_tdata_i[ANGLE_W-1:0];
  assign in_time   = s_axis_tdata_i[ANGLE_W +: TIME_W];
  assign in_op     = op_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (st_q == ST_IDLE);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // step size write: zero becomes one, large values saturate
  always_comb begin
    step_wr = cfg_wdata_i[STEP_W-1:0];
    if (step_wr == '0) begin
      step_wr = STEP_W'(1);
    end else if (step_wr > STEP_W'(STEP_MAX)) begin
      step_wr = STEP_W'(STEP_MAX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_W'(STEP_RESET);
      thr_q    <= THR_W'(THR_RESET);
      settle_q <= SETTLE_W'(SETTLE_RESET);
      maxp_q   <= MAXP_W'(MAXP_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_STEP_COUNTS:  step_q   <= step_wr;
        CFG_MOVE_THRESH:  thr_q    <= cfg_wdata_i[THR_W-1:0];
        CFG_IDLE_TIME:    settle_q <= cfg_wdata_i[SETTLE_W-1:0];
        CFG_MAX_PENDING:  maxp_q   <= cfg_wdata_i[MAXP_W-1:0];
        default: ;
      endcase
    end
  end

  // only the low ANGLE_BITS of the angle field are used
  assign ang_ext  = EW'(in_angle);
  assign ang      = ang_ext[AW-1:0];
  assign diff_raw = $signed({2'b00, ang}) - $signed({2'b00, prev_angle_q});

  // shortest way around the turn
  always_comb begin
    diff_w = diff_raw;
    if (diff_raw > HALF) begin
      diff_w = diff_raw - FULL;
    end else if (diff_raw < -HALF) begin
      diff_w = diff_raw + FULL;
    end
  end

  assign delta     = diff_w[DW-1:0];
  assign delta_abs = delta[DW-1] ? DW'(-delta) : DW'(delta);
  assign still     = (CW'(delta_abs) < CW'(thr_q));
  assign elapsed   = in_time - motion_q;
  assign acc_sum   = acc_q + ACC_W'(delta);
  assign acc_abs   = acc_sum[ACC_W-1] ? -acc_sum : acc_sum;

  // the accumulator magnitude goes through the divider
  assign div_start = in_accept && (in_op == OP_SAMPLE) && primed_q && !still;

  adtsc_div #(
    .DVD_W (MW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (acc_abs[MW-1:0]),
    .divisor_i   (step_q),
    .stat_o      (div_stat),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // remainder keeps the sign of the accumulator
  assign rem_s = ACC_W'(rem);
  assign p_ext = PW'(pend_q);
  assign q_ext = PW'(quo);
  assign lim   = PW'(maxp_q);

  // saturating pending update
  always_comb begin
    p_new = p_ext;
    if (!neg_q) begin
      if (p_ext < lim) begin
        p_new = p_ext + q_ext;
        if (p_new > lim) begin
          p_new = lim;
        end
      end
    end else begin
      if (p_ext > -lim) begin
        p_new = p_ext - q_ext;
        if (p_new < -lim) begin
          p_new = -lim;
        end
      end
    end
  end

  assign slot_free = !out_valid_q || m_axis_tready_i;

  // sequencer
  always_comb begin
    st_d         = st_q;
    primed_d     = primed_q;
    prev_angle_d = prev_angle_q;
    prev_delta_d = prev_delta_q;
    acc_d        = acc_q;
    total_d      = total_q;
    pend_d       = pend_q;
    motion_d     = motion_q;
    consumed_d   = consumed_q;
    neg_d        = neg_q;
    out_load     = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          st_d       = ST_OUT;
          consumed_d = '0;
          if (in_op == OP_CONSUME) begin
            consumed_d = pend_q;
            pend_d     = '0;
          end else if (!primed_q) begin
            // first sample only sets the reference
            primed_d     = 1'b1;
            prev_angle_d = ang;
            motion_d     = in_time;
          end else begin
            prev_angle_d = ang;
            prev_delta_d = delta;
            if (still) begin
              if (elapsed > TIME_W'(settle_q)) begin
                acc_d = '0;
              end
            end else begin
              motion_d = in_time;
              neg_d    = acc_sum[ACC_W-1];
              st_d     = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          st_d  = ST_OUT;
          acc_d = neg_q ? -rem_s : rem_s;
          if (quo != '0) begin
            total_d = neg_q ? total_q - COUNT_W'(quo) : total_q + COUNT_W'(quo);
            pend_d  = p_new[PEND_W-1:0];
          end
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      primed_q     <= 1'b0;
      prev_angle_q <= '0;
      prev_delta_q <= '0;
      acc_q        <= '0;
      total_q      <= '0;
      pend_q       <= '0;
      motion_q     <= '0;
      consumed_q   <= '0;
      neg_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      primed_q     <= primed_d;
      prev_angle_q <= prev_angle_d;
      prev_delta_q <= prev_delta_d;
      acc_q        <= acc_d;
      total_q      <= total_d;
      pend_q       <= pend_d;
      motion_q     <= motion_d;
      consumed_q   <= consumed_d;
      neg_q        <= neg_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result fields from the updated state
  assign ref_ext   = EW'(prev_angle_q);
  assign delta_ext = XW'(prev_delta_q);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {delta_ext[DELTA_W-1:0],
                     ref_ext[ANGLE_W-1:0],
                     (pend_q != '0),
                     consumed_q,
                     pend_q,
                     total_q};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

`ifndef NO_ASSERTIONS
  // divider runs exactly while the sequencer waits on it
  a_div_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (st_q == ST_DIV))
    else $error("divider busy outside the divide state");

  a_div_state_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("divide state without divider work");

  // a finished result is never dropped while the output slot is full
  a_out_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((st_q == ST_OUT) && out_valid_q && !m_axis_tready_i) |=> (st_q == ST_OUT))
    else $error("result left before the output slot was free");

  // nothing accumulates before the first reference sample
  a_unprimed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !primed_q |-> ((acc_q == '0) && (total_q == '0) && (pend_q == '0)))
    else $error("state moved before the first sample");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import adtsc_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int STALL_LIMIT   = 4000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES = 20;    // extra wait once every owed result is back
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 240;

  // result fields, highest bits first so the struct overlays m_axis_tdata_o
  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic [ANGLE_W-1:0]        ref_angle;
    logic                      has_steps;
    logic signed [PEND_W-1:0]  consumed;
    logic signed [PEND_W-1:0]  pending;
    logic [COUNT_W-1:0]        count;
  } detent_result_t;

  // predicts the detent counter and holds the results still owed by the block
  class detent_scoreboard;
    int             step_size;
    int             move_thresh;
    int             settle_time;
    int             pend_limit;
    bit             primed_q;
    logic [11:0]    last_angle;
    logic [12:0]    last_delta;
    int             accum;
    logic [31:0]    detent_total;
    int             pend;
    logic [31:0]    last_motion_ms;
    detent_result_t owed_q[$];
    int unsigned    mismatches;

    function new();
      step_size      = STEP_RESET;
      move_thresh    = THR_RESET;
      settle_time    = SETTLE_RESET;
      pend_limit     = MAXP_RESET;
      primed_q       = 1'b0;
      last_angle     = '0;
      last_delta     = '0;
      accum          = 0;
      detent_total   = '0;
      pend           = 0;
      last_motion_ms = '0;
      mismatches     = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      int v;
      case (idx)
        CFG_STEP_COUNTS: begin
          v = int'(val[STEP_W-1:0]);
          if (v == 0) v = 1;
          if (v > STEP_MAX) v = STEP_MAX;
          step_size = v;
        end
        CFG_MOVE_THRESH: move_thresh = int'(val[THR_W-1:0]);
        CFG_IDLE_TIME:   settle_time = int'(val[SETTLE_W-1:0]);
        CFG_MAX_PENDING: pend_limit  = int'(val[MAXP_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_item(op_e op, logic [11:0] ang, logic [31:0] now);
      int             d;
      int             mag;
      int             q;
      int             taken;
      logic [31:0]    idle_ms;
      detent_result_t r;
      taken = 0;
      if (op == OP_CONSUME) begin
        taken = pend;
        pend  = 0;
      end else if (!primed_q) begin
        // first sample only sets the reference
        primed_q       = 1'b1;
        last_angle     = ang;
        last_motion_ms = now;
      end else begin
        d = int'(ang) - int'(last_angle);
        if (d > 2048) d -= 4096;
        if (d < -2048) d += 4096;
        last_angle = ang;
        last_delta = d[12:0];
        mag = (d < 0) ? -d : d;
        if (mag < move_thresh) begin
          idle_ms = now - last_motion_ms;
          if (idle_ms > settle_time) accum = 0;
        end else begin
          last_motion_ms = now;
          accum += d;
          mag = (accum < 0) ? -accum : accum;
          q = mag / step_size;
          if (q != 0) begin
            if (accum > 0) begin
              accum -= q * step_size;
              detent_total += q;
              if (pend < pend_limit) begin
                pend += q;
                if (pend > pend_limit) pend = pend_limit;
              end
            end else begin
              accum += q * step_size;
              detent_total -= q;
              if (pend > -pend_limit) begin
                pend -= q;
                if (pend < -pend_limit) pend = -pend_limit;
              end
            end
          end
        end
      end
      r.count     = detent_total;
      r.pending   = pend[6:0];
      r.consumed  = taken[6:0];
      r.has_steps = (pend != 0);
      r.ref_angle = last_angle;
      r.delta     = last_delta;
      owed_q.push_back(r);
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(detent_result_t got);
      detent_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none got %h", $time, got);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      field_check("detent_count", want.count, got.count);
      field_check("pending_steps", want.pending, got.pending);
      field_check("consumed_steps", want.consumed, got.consumed);
      field_check("has_steps", want.has_steps, got.has_steps);
      field_check("reference_angle", want.ref_angle, got.ref_angle);
      field_check("angle_delta", want.delta, got.delta);
    endfunction

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  // block ports
  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;   // angle [11:0], time_ms [43:12], zero [47:44]
  logic                   s_axis_tuser_i;   // operation [0]
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // detent_count [31:0], pending_steps [38:32], consumed_steps [45:39],
  // has_steps [46], reference_angle [58:47], angle_delta [71:59]
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;

  detent_scoreboard sb;

  // idle odds in percent for each side, changed per phase
  int src_idle_pct;
  int dst_idle_pct;
  int stall_cycles;

  // walking angle and timestamp for the well-formed random samples
  int          gen_angle;
  logic [31:0] gen_time;
  int          heading;

  angle_to_detent_step_counter_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // receiver stalls at random with the odds of the current phase
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= dst_idle_pct);
  end

  // both handshakes are sampled at the edge, before any driver update lands;
  // the watchdog counts cycles in which no item moves on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.note_item(op_e'(s_axis_tuser_i), s_axis_tdata_i[11:0], s_axis_tdata_i[43:12]);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(detent_result_t'(m_axis_tdata_o));
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[angle_to_detent_step_counter_unit] ERROR");
        $finish;
      end
    end
  end

  // offers one item after a random gap and returns at the edge that takes it
  task automatic push_item(op_e op, logic [11:0] ang, logic [31:0] now);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {4'b0000, now, ang};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // holds the sender off until every owed result is back, then lets the block settle
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves cfg_we_i high; the caller lowers it after the last write
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  // register setting, stimulus shape and idle odds of one random phase
  task automatic start_phase(int k, output int span, output int consume_pct);
    logic [15:0] w_step;
    logic [15:0] w_thr;
    logic [15:0] w_settle;
    logic [15:0] w_maxp;
    case (k)
      // step of zero becomes one, zero threshold makes every sample move
      0: begin w_step = 16'h0000; w_thr = 16'h0000; w_settle = 16'hFFFF; w_maxp = 16'h003F;
               span = 8;    consume_pct = 2;  end
      // oversized step saturates; lowering max_pending leaves pending where it is
      1: begin w_step = 16'h1FFF; w_thr = 16'h0800; w_settle = 16'h0000; w_maxp = 16'h0001;
               span = 2048; consume_pct = 10; end
      // threshold above half a turn, nothing counts as motion
      2: begin w_step = 16'd12;   w_thr = 16'h0801; w_settle = 16'd40;   w_maxp = 16'd20;
               span = 2048; consume_pct = 10; end
      // zero max_pending keeps pending at zero
      3: begin w_step = 16'd4096; w_thr = 16'd1;    w_settle = 16'd1000; w_maxp = 16'd0;
               span = 600;  consume_pct = 10; end
      // upper write bits fall outside the step, threshold and max_pending registers
      4: begin w_step = 16'hA007; w_thr = 16'hF003; w_settle = 16'd5;    w_maxp = 16'hFFC5;
               span = 30;   consume_pct = 8;  end
      5: begin w_step = 16'd4097; w_thr = 16'd1;    w_settle = 16'd100;  w_maxp = 16'd40;
               span = 1500; consume_pct = 5;  end
      6: begin w_step = 16'd24;   w_thr = 16'd4;    w_settle = 16'd40;   w_maxp = 16'd3;
               span = 60;   consume_pct = 12; end
      default: begin
               w_step = 16'd1000; w_thr = 16'd2047; w_settle = 16'hFFFF; w_maxp = 16'd63;
               span = 2048; consume_pct = 6;  end
    endcase
    write_reg(CFG_STEP_COUNTS, w_step);
    write_reg(CFG_MOVE_THRESH, w_thr);
    write_reg(CFG_IDLE_TIME, w_settle);
    write_reg(CFG_MAX_PENDING, w_maxp);
    cfg_we_i <= 1'b0;
    // receiver idles first, then the sender, then neither
    src_idle_pct = (k < 3) ? 14 : (k < 6) ? 82 : 0;
    dst_idle_pct = (k < 3) ? 82 : (k < 6) ? 14 : 0;
    gen_time     = (k == NUM_PHASES - 1) ? 32'hFFFF_F000 : $urandom;
  endtask

  // mostly a knob turned one way for a while with rising timestamps,
  // sprinkled with still samples, consumes and fully random noise
  task automatic random_item(int span, int consume_pct);
    int r;
    int d;
    r = $urandom_range(99);
    if (r < consume_pct) begin
      push_item(OP_CONSUME, 12'($urandom), $urandom);
    end else if (r < consume_pct + 5) begin
      gen_angle = $urandom_range(4095);
      gen_time  = $urandom;
      push_item(OP_SAMPLE, 12'(gen_angle), gen_time);
    end else begin
      if ($urandom_range(9) == 0) heading = -heading;
      if ($urandom_range(9) < 2) begin
        d = int'($urandom_range(2)) - 1;  // still or jitter
      end else begin
        d = heading * int'($urandom_range(span));
      end
      gen_angle = (gen_angle + d) & 4095;
      case ($urandom_range(19))
        0:       gen_time = gen_time + $urandom_range(70000);
        1:       gen_time = gen_time + $urandom_range(1100);
        default: gen_time = gen_time + $urandom_range(60);
      endcase
      push_item(OP_SAMPLE, 12'(gen_angle), gen_time);
    end
  endtask

  initial begin
    int span;
    int consume_pct;
    sb = new();
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tuser_i  <= 1'b0;
    s_axis_tdata_i  <= '0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= '0;
    cfg_wdata_i     <= '0;
    src_idle_pct = 14;
    dst_idle_pct = 82;
    gen_angle    = 0;
    gen_time     = '0;
    heading      = 1;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset setting: step 12, threshold 1, settle 40, limit 20
    push_item(OP_CONSUME, 12'hFFF, 32'hFFFF_FFFF);  // consume before anything happened
    push_item(OP_SAMPLE,  12'h000, 32'd0);          // first sample only primes
    push_item(OP_SAMPLE,  12'hFFF, 32'd1);          // one count back across zero
    push_item(OP_SAMPLE,  12'h7FF, 32'd2);          // half a turn back, pending hits -limit
    push_item(OP_SAMPLE,  12'hFFF, 32'd3);          // half a turn forward, pending hits +limit
    push_item(OP_SAMPLE,  12'hFFF, 32'd10);         // still, well inside settle time
    push_item(OP_SAMPLE,  12'hFFF, 32'd43);         // still, exactly at settle time
    push_item(OP_SAMPLE,  12'hFFF, 32'd44);         // still, past settle time: clears
    push_item(OP_CONSUME, 12'h000, 32'd0);
    push_item(OP_SAMPLE,  12'hFFA, 32'hFFFF_FFF0);  // motion just before the timestamp wraps
    push_item(OP_SAMPLE,  12'hFFA, 32'h0000_0018);  // idle time across the wrap equals settle
    push_item(OP_SAMPLE,  12'hFFA, 32'h0000_0019);  // one past: clears
    push_item(OP_SAMPLE,  12'h00A, 32'h0000_0020);  // forward across zero, one whole step
    push_item(OP_SAMPLE,  12'hAAA, 32'h5555_5555);
    push_item(OP_SAMPLE,  12'h555, 32'hAAAA_AAAA);
    push_item(OP_CONSUME, 12'h555, 32'h1234_5678);
    push_item(OP_CONSUME, 12'h000, 32'd0);          // nothing left to consume
    drain();

    // random phases, registers rewritten only with the block drained
    for (int k = 0; k < NUM_PHASES; k++) begin
      start_phase(k, span, consume_pct);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item(span, consume_pct);
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[angle_to_detent_step_counter_unit] OK");
    end else begin
      $display("[angle_to_detent_step_counter_unit] ERROR");
    end
    $finish;
  end

endmodule
